FILE: hdl/pra_pkg.sv
`timescale 1ns / 1ps

package pra_pkg;

  // Bitmap storage word: 64 pages per word.
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned WORD_LOG  = 6;

  // Field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned PAGE_W     = 10;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned WSTART_W   = 10;
  localparam int unsigned WSTOP_W    = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [WSTART_W-1:0] WSTART_RESET = 10'd0;
  localparam logic [WSTOP_W-1:0]  WSTOP_RESET  = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_START = 1'b0,
    REG_WIN_STOP  = 1'b1
  } cfg_reg_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_ZERO_LEN    = 3'd1,
    ST_NO_RUN      = 3'd2,
    ST_OUTSIDE     = 3'd3,
    ST_DOUBLE_FREE = 3'd4
  } status_e;

  // Word operation issued by the sweep counter
  typedef enum logic [2:0] {
    OP_WIPE  = 3'd0,
    OP_FILL  = 3'd1,
    OP_SCAN  = 3'd2,
    OP_CHECK = 3'd3,
    OP_CLR   = 3'd4,
    OP_SET   = 3'd5
  } op_e;

  // Source of the page range that a sweep covers
  typedef enum logic [1:0] {
    RNG_WIN = 2'd0,
    RNG_RUN = 2'd1,
    RNG_HIT = 2'd2
  } rng_sel_e;

  // Free count update applied with the result
  typedef enum logic [1:0] {
    FC_NONE  = 2'd0,
    FC_INIT  = 2'd1,
    FC_ALLOC = 2'd2,
    FC_FREE  = 2'd3
  } fc_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  run_length;
    logic [PAGE_W-1:0] page_index;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   start_page;
    logic [COUNT_W-1:0]  free_pages;
  } result_t;

  typedef struct packed {
    logic     capture;
    logic     load_rng;
    rng_sel_e rng_sel;
    logic     from_zero;
    logic     step;
    op_e      op;
    logic     clr_acc;
    logic     finish;
    status_e  status;
    fc_e      fc;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             len_zero;
    logic             len_gt_free;
    logic             win_empty;
    logic             outside;
    logic             last;
    logic             pipe_busy;
    logic             found;
    logic             clash;
  } dp_stat_t;

endpackage

FILE: hdl/page_run_bitmap_allocator.sv
`timescale 1ns / 1ps

// Channel  | Handshake                 | Payload
// ---------+---------------------------+---------------------------------------
// item in  | start & !busy             | item_i (command, run_length, page_index)
// result   | done_o, one cycle strobe  | result_o (status, start_page, free_pages)
// config   | cfg_valid_i & cfg_ready_o | cfg_index_i, cfg_data_i
//
// The free map sits in a RAM of 64-page words, one read and one write per
// cycle; init, alloc and free sweep it one word a cycle unless rejected.
// Init fills the window; alloc scans it, then clears the run found; free
// checks the run, then sets it. After reset the map is wiped with busy
// high. The result sink cannot stall: results are strobed once on done_o,
// and the next item may start meanwhile.

module page_run_bitmap_allocator #(
  parameter int unsigned MAX_PAGES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item channel
  input  logic                           start,
  output logic                           busy,
  input  pra_pkg::item_t                 item_i,
  // result channel
  output logic                           done_o,
  output pra_pkg::result_t               result_o,
  // configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pra_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import pra_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Window registers take writes at any time; only idle writes are meaningful.
  assign cfg_ready_o = 1'b1;

  // Sequence the sweeps: wipe, fill, scan, check, set and clear
  pra_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  // Hold the map, the free count and the item; search and update word by word
  pra_dp #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

FILE: hdl/pra_ram.sv
`timescale 1ns / 1ps

module pra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hdl/pra_ctrl.sv
`timescale 1ns / 1ps

module pra_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pra_pkg::dp_stat_t  stat_i,
  output pra_pkg::dp_cmd_t   cmd_o
);

  import pra_pkg::*;

  typedef enum logic [9:0] {
    S_WIPE   = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_DECIDE = 10'b0000000100,
    S_FILL   = 10'b0000001000,
    S_SCAN   = 10'b0000010000,
    S_SDRAIN = 10'b0000100000,
    S_CLEAR  = 10'b0001000000,
    S_CHECK  = 10'b0010000000,
    S_CDRAIN = 10'b0100000000,
    S_SET    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_WIPE: begin
        cmd_o.step = 1'b1;
        cmd_o.op   = OP_WIPE;
        if (stat_i.last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat_i.command)
          CMD_INIT: begin
            cmd_o.load_rng  = 1'b1;
            cmd_o.rng_sel   = RNG_WIN;
            cmd_o.from_zero = 1'b1;
            state_d         = S_FILL;
          end
          CMD_ALLOC: begin
            if (stat_i.len_zero) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_ZERO_LEN;
              state_d      = S_IDLE;
            end else if (stat_i.len_gt_free || stat_i.win_empty) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_NO_RUN;
              state_d      = S_IDLE;
            end else begin
              cmd_o.load_rng = 1'b1;
              cmd_o.rng_sel  = RNG_WIN;
              cmd_o.clr_acc  = 1'b1;
              state_d        = S_SCAN;
            end
          end
          CMD_FREE: begin
            if (stat_i.len_zero) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_ZERO_LEN;
              state_d      = S_IDLE;
            end else if (stat_i.outside) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = ST_OUTSIDE;
              state_d      = S_IDLE;
            end else begin
              cmd_o.load_rng = 1'b1;
              cmd_o.rng_sel  = RNG_RUN;
              cmd_o.clr_acc  = 1'b1;
              state_d        = S_CHECK;
            end
          end
          default: begin
            // unused command code: answer ok, touch nothing
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_OK;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_FILL: begin
        cmd_o.step = 1'b1;
        cmd_o.op   = OP_FILL;
        if (stat_i.last) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_OK;
          cmd_o.fc     = FC_INIT;
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat_i.found) begin
          cmd_o.load_rng = 1'b1;
          cmd_o.rng_sel  = RNG_HIT;
          state_d        = S_CLEAR;
        end else begin
          cmd_o.step = 1'b1;
          cmd_o.op   = OP_SCAN;
          if (stat_i.last) begin
            state_d = S_SDRAIN;
          end
        end
      end
      S_SDRAIN: begin
        if (stat_i.found) begin
          cmd_o.load_rng = 1'b1;
          cmd_o.rng_sel  = RNG_HIT;
          state_d        = S_CLEAR;
        end else if (!stat_i.pipe_busy) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_NO_RUN;
          state_d      = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd_o.step = 1'b1;
        cmd_o.op   = OP_CLR;
        if (stat_i.last) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_OK;
          cmd_o.fc     = FC_ALLOC;
          state_d      = S_IDLE;
        end
      end
      S_CHECK: begin
        cmd_o.step = 1'b1;
        cmd_o.op   = OP_CHECK;
        if (stat_i.last) begin
          state_d = S_CDRAIN;
        end
      end
      S_CDRAIN: begin
        if (!stat_i.pipe_busy) begin
          if (stat_i.clash) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_DOUBLE_FREE;
            state_d      = S_IDLE;
          end else begin
            cmd_o.load_rng = 1'b1;
            cmd_o.rng_sel  = RNG_RUN;
            state_d        = S_SET;
          end
        end
      end
      S_SET: begin
        cmd_o.step = 1'b1;
        cmd_o.op   = OP_SET;
        if (stat_i.last) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_OK;
          cmd_o.fc     = FC_FREE;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_WIPE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/pra_dp.sv
`timescale 1ns / 1ps

module pra_dp #(
  parameter int unsigned MAX_PAGES = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [pra_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pra_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  pra_pkg::item_t                      item_i,
  input  pra_pkg::dp_cmd_t                    cmd_i,
  output pra_pkg::dp_stat_t                   stat_o,
  output logic                                done_o,
  output pra_pkg::result_t                    result_o
);

  import pra_pkg::*;

  localparam int unsigned WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PW    = $clog2(MAX_PAGES + 1);
  localparam int unsigned CW    = (PW > LEN_W) ? PW : LEN_W;
  localparam int unsigned GW    = (PW > AW + WORD_LOG) ? PW : AW + WORD_LOG;
  localparam int unsigned XW    = ((GW > CW) ? GW : CW) + 1;
  localparam int unsigned ZW    = WORD_LOG + 1;

  // Configuration
  logic [WSTART_W-1:0] win_start_q;
  logic [WSTOP_W-1:0]  win_stop_q;

  // Command in flight and counters
  item_t              item_q;
  logic [PW-1:0]      free_q;
  logic [XW-1:0]      rng_lo_q, rng_hi_q;
  logic [AW-1:0]      addr_q, end_w_q;
  logic [XW-1:0]      start_q;

  // Read pipeline
  logic               rd_vld_q;
  op_e                rd_op_q;
  logic [AW-1:0]      rd_addr_q;
  logic [WORD_BITS-1:0] rd_data;

  // Scan pipeline
  logic               a_vld_q;
  logic [WORD_BITS-1:0] hit_q, hit_d;
  logic [AW-1:0]      hit_w_q;
  logic [XW-1:0]      carry_q, carry_d;
  logic               clash_q;

  logic               done_q;
  result_t            result_q;

  logic [XW-1:0]      lo_x, hi_x, len_x, page_x, fc_x;
  logic [XW-1:0]      nlo, nhi;
  logic [XW-1:0]      hit_end_x, hit_first_x;
  logic [WORD_LOG-1:0] hit_pos;
  logic [WORD_BITS-1:0] mask_sw, mask_rd, sm;
  logic [ZW-1:0]      zl [WORD_LOG+1][WORD_BITS];
  logic [XW-1:0]      run_v;
  logic               is_rd_op, ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [XW-1:0]      nfc;

  function automatic logic [AW-1:0] word_of(input logic [XW-1:0] x);
    logic [XW-1:0] s;
    s = x >> WORD_LOG;
    return s[AW-1:0];
  endfunction

  // Pages of word w that fall in [lo, hi)
  function automatic logic [WORD_BITS-1:0] range_mask(input logic [AW-1:0] w,
                                                      input logic [XW-1:0] lo,
                                                      input logic [XW-1:0] hi);
    logic [XW-1:0]        g;
    logic [WORD_BITS-1:0] m;
    for (int b = 0; b < WORD_BITS; b++) begin
      g    = XW'({w, WORD_LOG'(b)});
      m[b] = (g >= lo) && (g < hi);
    end
    return m;
  endfunction

  // Clamp window to the map
  assign lo_x   = (XW'(win_start_q) > XW'(MAX_PAGES)) ? XW'(MAX_PAGES) : XW'(win_start_q);
  assign hi_x   = (XW'(win_stop_q) > XW'(MAX_PAGES)) ? XW'(MAX_PAGES) : XW'(win_stop_q);
  assign len_x  = XW'(item_q.run_length);
  assign page_x = XW'(item_q.page_index);
  assign fc_x   = XW'(free_q);

  always_comb begin
    case (cmd_i.rng_sel)
      RNG_RUN: begin
        nlo = page_x;
        nhi = page_x + len_x;
      end
      RNG_HIT: begin
        nlo = hit_first_x;
        nhi = hit_end_x + XW'(1);
      end
      default: begin
        nlo = lo_x;
        nhi = hi_x;
      end
    endcase
  end

  assign mask_sw = range_mask(addr_q, rng_lo_q, rng_hi_q);
  assign mask_rd = range_mask(rd_addr_q, rng_lo_q, rng_hi_q);

  // Memory ports
  assign is_rd_op = (cmd_i.op != OP_WIPE) && (cmd_i.op != OP_FILL);
  assign ram_re   = cmd_i.step && is_rd_op;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    if (cmd_i.step && !is_rd_op) begin
      ram_we    = 1'b1;
      ram_wdata = (cmd_i.op == OP_FILL) ? mask_sw : '0;
    end else if (rd_vld_q && (rd_op_q == OP_CLR)) begin
      ram_we    = 1'b1;
      ram_waddr = rd_addr_q;
      ram_wdata = rd_data & ~mask_rd;
    end else if (rd_vld_q && (rd_op_q == OP_SET)) begin
      ram_we    = 1'b1;
      ram_waddr = rd_addr_q;
      ram_wdata = rd_data | mask_rd;
    end
  end

  pra_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (rd_data)
  );

  // Run search over one word: zl holds, per bit, one past the nearest page at
  // or below it that is used or outside the range (zero if none in the word).
  always_comb begin
    sm = rd_data & mask_rd;
    for (int p = 0; p < WORD_BITS; p++) begin
      zl[0][p] = sm[p] ? '0 : ZW'(p + 1);
    end
    for (int k = 0; k < WORD_LOG; k++) begin
      for (int p = 0; p < WORD_BITS; p++) begin
        if ((p >= (1 << k)) && (zl[k][p] == '0)) begin
          zl[k+1][p] = zl[k][p - (1 << k)];
        end else begin
          zl[k+1][p] = zl[k][p];
        end
      end
    end
    run_v = '0;
    for (int p = 0; p < WORD_BITS; p++) begin
      if (zl[WORD_LOG][p] == '0) begin
        run_v = carry_q + XW'(p + 1);
      end else begin
        run_v = XW'(p + 1) - XW'(zl[WORD_LOG][p]);
      end
      hit_d[p] = sm[p] && (run_v >= len_x);
    end
    if (zl[WORD_LOG][WORD_BITS-1] == '0) begin
      carry_d = carry_q + XW'(WORD_BITS);
    end else begin
      carry_d = XW'(WORD_BITS) - XW'(zl[WORD_LOG][WORD_BITS-1]);
    end
  end

  // Lowest hit gives the end page of the first fitting run
  always_comb begin
    hit_pos = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (hit_q[p]) begin
        hit_pos = WORD_LOG'(p);
      end
    end
  end

  assign hit_end_x   = XW'({hit_w_q, hit_pos});
  assign hit_first_x = hit_end_x + XW'(1) - len_x;

  always_comb begin
    case (cmd_i.fc)
      FC_INIT:  nfc = (lo_x >= hi_x) ? '0 : hi_x - lo_x;
      FC_ALLOC: nfc = fc_x - len_x;
      FC_FREE:  nfc = fc_x + len_x;
      default:  nfc = fc_x;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= WSTART_RESET;
      win_stop_q  <= WSTOP_RESET;
      free_q      <= '0;
      addr_q      <= '0;
      end_w_q     <= AW'(WORDS - 1);
      rd_vld_q    <= 1'b0;
      a_vld_q     <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_WIN_START: win_start_q <= cfg_data_i[WSTART_W-1:0];
          REG_WIN_STOP:  win_stop_q  <= cfg_data_i[WSTOP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load_rng) begin
        addr_q  <= cmd_i.from_zero ? '0 : word_of(nlo);
        end_w_q <= cmd_i.from_zero ? AW'(WORDS - 1) : word_of(nhi - XW'(1));
      end else if (cmd_i.step) begin
        addr_q <= addr_q + 1'b1;
      end
      if (cmd_i.finish) begin
        free_q <= nfc[PW-1:0];
      end
      rd_vld_q <= ram_re;
      a_vld_q  <= rd_vld_q && (rd_op_q == OP_SCAN);
      done_q   <= cmd_i.finish;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.load_rng) begin
      rng_lo_q <= nlo;
      rng_hi_q <= nhi;
      if (cmd_i.rng_sel == RNG_HIT) begin
        start_q <= hit_first_x;
      end
    end
    rd_op_q   <= cmd_i.op;
    rd_addr_q <= addr_q;
    if (rd_vld_q && (rd_op_q == OP_SCAN)) begin
      hit_q   <= hit_d;
      hit_w_q <= rd_addr_q;
    end
    if (cmd_i.clr_acc) begin
      carry_q <= '0;
      clash_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (rd_op_q == OP_SCAN) begin
        carry_q <= carry_d;
      end
      if (rd_op_q == OP_CHECK) begin
        clash_q <= clash_q | (|(rd_data & mask_rd));
      end
    end
    if (cmd_i.finish) begin
      result_q.status     <= cmd_i.status;
      result_q.start_page <= (cmd_i.fc == FC_ALLOC) ? start_q[PAGE_W-1:0] : '0;
      result_q.free_pages <= nfc[COUNT_W-1:0];
    end
  end

  assign stat_o.command     = item_q.command;
  assign stat_o.len_zero    = (item_q.run_length == '0);
  assign stat_o.len_gt_free = (len_x > fc_x);
  assign stat_o.win_empty   = (lo_x >= hi_x);
  assign stat_o.outside     = (page_x < lo_x) || ((page_x + len_x) > hi_x);
  assign stat_o.last        = (addr_q == end_w_q);
  assign stat_o.pipe_busy   = rd_vld_q || a_vld_q;
  assign stat_o.found       = a_vld_q && (|hit_q);
  assign stat_o.clash       = clash_q;

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

FILE: test/page_map_monitor.sv
`timescale 1ns / 1ps

module page_map_monitor #(
  parameter int unsigned MAX_PAGES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  pra_pkg::item_t                 item_i,
  input  logic                           done_i,
  input  pra_pkg::result_t               result_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [pra_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pra_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);

  import pra_pkg::*;

  logic [MAX_PAGES-1:0] page_free;
  int unsigned          pages_free;
  logic [WSTART_W-1:0]  win_first;
  logic [WSTOP_W-1:0]   win_end;
  result_t              owed[$];
  int unsigned          faults = 0;

  task automatic report_fault(input string msg);
    $display("[%0t] page map: %s", $time, msg);
    faults++;
  endtask

  // Apply one item to the shadow page map and return the reply it should give.
  function automatic result_t apply_page_op(input item_t it);
    result_t     res;
    int unsigned lo, hi, len, pg, run, last, p;
    bit          hit;
    lo  = (win_first > MAX_PAGES) ? MAX_PAGES : 32'(win_first);
    hi  = (win_end > MAX_PAGES) ? MAX_PAGES : 32'(win_end);
    len = 32'(it.run_length);
    pg  = 32'(it.page_index);
    res.status     = ST_OK;
    res.start_page = '0;
    case (it.command)
      CMD_INIT: begin
        page_free  = '0;
        pages_free = 0;
        for (p = lo; p < hi; p++) begin
          page_free[p] = 1'b1;
          pages_free++;
        end
      end
      CMD_ALLOC: begin
        if (len == 0) begin
          res.status = ST_ZERO_LEN;
        end else if (len > pages_free) begin
          res.status = ST_NO_RUN;
        end else begin
          run  = 0;
          hit  = 1'b0;
          last = 0;
          for (p = lo; p < hi && !hit; p++) begin
            if (!page_free[p]) begin
              run = 0;
            end else begin
              run++;
              if (run == len) begin
                hit  = 1'b1;
                last = p;
              end
            end
          end
          if (hit) begin
            for (p = last + 1 - len; p <= last; p++) page_free[p] = 1'b0;
            pages_free     -= len;
            res.start_page = PAGE_W'(last + 1 - len);
          end else begin
            res.status = ST_NO_RUN;
          end
        end
      end
      CMD_FREE: begin
        if (len == 0) begin
          res.status = ST_ZERO_LEN;
        end else if (pg < lo || pg + len > hi) begin
          res.status = ST_OUTSIDE;
        end else begin
          hit = 1'b0;
          for (p = pg; p < pg + len; p++) begin
            if (page_free[p]) hit = 1'b1;
          end
          if (hit) begin
            res.status = ST_DOUBLE_FREE;
          end else begin
            for (p = pg; p < pg + len; p++) page_free[p] = 1'b1;
            pages_free += len;
          end
        end
      end
      default: ;
    endcase
    res.free_pages = COUNT_W'(pages_free);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      win_first  = WSTART_RESET;
      win_end    = WSTOP_RESET;
      page_free  = '0;
      pages_free = 0;
      owed.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_WIN_START: win_first = cfg_data_i[WSTART_W-1:0];
          REG_WIN_STOP:  win_end   = cfg_data_i[WSTOP_W-1:0];
          default: ;
        endcase
      end
      if ($isunknown(done_i)) begin
        report_fault("result strobe is unknown");
      end else if (done_i) begin
        if (owed.size() == 0) begin
          report_fault($sformatf("reply with no item waiting: status %0d start %0d free %0d",
                                 result_i.status, result_i.start_page, result_i.free_pages));
        end else begin
          want = owed.pop_front();
          if (result_i.status !== want.status)
            report_fault($sformatf("status %0d, expected %0d",
                                   result_i.status, want.status));
          if (result_i.start_page !== want.start_page)
            report_fault($sformatf("start_page %0d, expected %0d",
                                   result_i.start_page, want.start_page));
          if (result_i.free_pages !== want.free_pages)
            report_fault($sformatf("free_pages %0d, expected %0d",
                                   result_i.free_pages, want.free_pages));
        end
      end
      if (start_i && !busy_i) owed.push_back(apply_page_op(item_i));
      fail_count_o <= faults;
      pending_o    <= owed.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

  import pra_pkg::*;

  localparam int unsigned PAGES         = 1024;
  localparam int unsigned PHASES        = 15;
  // Longest quiet stretch in a correct run is a sender gap plus the sweeps
  // of one command; allow many times that.
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 80;
  // Command code with no meaning: the block must answer ok and do nothing.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [PAGE_W-1:0] first;
    logic [LEN_W-1:0]  len;
  } page_run_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  item_t                 item_i      = '0;
  logic                  done_o;
  result_t               result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  int unsigned           faults_seen;
  int unsigned           owed_count;

  // Items in flight (acceptance order) and runs known to be allocated,
  // kept only to steer the stimulus towards meaningful frees.
  item_t                 sent_items[$];
  page_run_t             held_runs[$];
  bit                    gaps_on;

  initial forever #4 clk_i = ~clk_i;

  page_run_bitmap_allocator #(
    .MAX_PAGES (PAGES)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  page_map_monitor #(
    .MAX_PAGES (PAGES)
  ) u_page_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item_i),
    .done_i       (done_o),
    .result_i     (result_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (faults_seen),
    .pending_o    (owed_count)
  );

  // Wait for a clock edge, then note what the reply on that edge tells about
  // allocated runs. Outputs read here still hold their pre-edge values.
  task automatic next_edge();
    item_t     it;
    page_run_t r;
    @(posedge clk_i);
    if (done_o === 1'b1 && sent_items.size() != 0) begin
      it = sent_items.pop_front();
      if (it.command == CMD_INIT) begin
        held_runs.delete();
      end else if (it.command == CMD_ALLOC && result_o.status == ST_OK) begin
        r.first = result_o.start_page;
        r.len   = it.run_length;
        held_runs.push_back(r);
      end
    end
  endtask

  // Present one item and hold it until accepted; start stays high on return,
  // so the caller either presents the next item or drops start in this step.
  task automatic issue_op(input logic [CMD_W-1:0]  cmd,
                          input logic [LEN_W-1:0]  len,
                          input logic [PAGE_W-1:0] page);
    item_t it;
    if (gaps_on && $urandom_range(6) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(17, 1)) next_edge();
    end
    it.command    = cmd;
    it.run_length = len;
    it.page_index = page;
    start  <= 1'b1;
    item_i <= it;
    do next_edge(); while (busy !== 1'b0);
    sent_items.push_back(it);
  endtask

  // Drop start and hold off until every reply owed has arrived.
  task automatic drain_results();
    start <= 1'b0;
    next_edge();
    while (owed_count != 0) next_edge();
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do next_edge(); while (cfg_ready_o !== 1'b1);
  endtask

  // Write both window registers back to back, in random order.
  task automatic set_window(input int unsigned first, input int unsigned stop);
    if ($urandom_range(1)) begin
      write_reg(REG_WIN_STOP, CFG_DATA_W'(stop));
      write_reg(REG_WIN_START, CFG_DATA_W'(first));
    end else begin
      write_reg(REG_WIN_START, CFG_DATA_W'(first));
      write_reg(REG_WIN_STOP, CFG_DATA_W'(stop));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly short runs, some long ones, the odd zero or oversize length.
  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned p = $urandom_range(99);
    if (p < 70) return LEN_W'($urandom_range(16, 1));
    if (p < 90) return LEN_W'($urandom_range(128, 17));
    if (p < 97) return LEN_W'($urandom_range(1024, 129));
    if (p < 98) return '0;
    return LEN_W'($urandom_range(2047, 1025));
  endfunction

  // Random item: allocations and frees of runs handed out earlier dominate,
  // with stray frees, the occasional init and unused command as noise.
  task automatic issue_random_op();
    int unsigned pick, k, off;
    page_run_t   r;
    pick = $urandom_range(99);
    if (pick < 45) begin
      issue_op(CMD_ALLOC, pick_len(), PAGE_W'($urandom));
    end else if (pick < 80 && held_runs.size() != 0) begin
      k = $urandom_range(held_runs.size() - 1);
      r = held_runs[k];
      case ($urandom_range(4))
        0, 1, 2: begin
          held_runs.delete(k);
          issue_op(CMD_FREE, r.len, r.first);
        end
        3: begin
          // part of a run: the rest stays allocated
          off = $urandom_range(r.len - 1);
          issue_op(CMD_FREE, LEN_W'($urandom_range(r.len - off, 1)),
                   PAGE_W'(r.first + off));
        end
        default: begin
          // spill past the run's end into whatever follows it
          issue_op(CMD_FREE, LEN_W'(r.len + $urandom_range(8, 1)), r.first);
        end
      endcase
    end else if (pick < 95) begin
      issue_op(CMD_FREE, pick_len(), PAGE_W'($urandom));
    end else if (pick < 98) begin
      issue_op(CMD_INIT, LEN_W'($urandom), PAGE_W'($urandom));
    end else begin
      issue_op(CMD_SPARE, LEN_W'($urandom), PAGE_W'($urandom));
    end
  endtask

  // Watchdog: end the run when nothing is accepted for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o === 1'b1 || (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase, count, lo, hi;
    bit          with_init;
    gaps_on = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset window, map starts with nothing free.
    issue_op(CMD_ALLOC, 11'd1, 10'd0);      // nothing free yet
    issue_op(CMD_FREE, 11'd1, 10'd0);       // page in use after reset: frees it
    issue_op(CMD_INIT, 11'd2047, 10'd1023); // length and page ignored
    issue_op(CMD_ALLOC, 11'd0, 10'd0);      // zero length
    issue_op(CMD_FREE, 11'd0, 10'd5);       // zero length
    issue_op(CMD_ALLOC, 11'd1024, 10'd0);   // whole map
    issue_op(CMD_ALLOC, 11'd1, 10'd0);      // more than the free count
    issue_op(CMD_FREE, 11'd2, 10'd1023);    // runs past the window stop
    issue_op(CMD_FREE, 11'd1024, 10'd0);    // ends exactly at the stop
    issue_op(CMD_FREE, 11'd1, 10'd1023);    // double free
    issue_op(CMD_SPARE, 11'd7, 10'd9);
    issue_op(CMD_ALLOC, 11'd3, 10'd0);
    issue_op(CMD_ALLOC, 11'd5, 10'd0);
    issue_op(CMD_FREE, 11'd3, 10'd0);       // leave a hole of three
    issue_op(CMD_ALLOC, 11'd4, 10'd0);      // skips the hole
    issue_op(CMD_ALLOC, 11'd2, 10'd0);      // first fit lands in the hole
    issue_op(CMD_ALLOC, 11'd1013, 10'd0);   // enough pages, none contiguous

    // Shrink the window without init: pages outside stay counted.
    drain_results();
    set_window(100, 200);
    issue_op(CMD_ALLOC, 11'd150, 10'd0);    // fits the count, not the window
    issue_op(CMD_ALLOC, 11'd50, 10'd0);
    issue_op(CMD_FREE, 11'd1, 10'd99);      // below the window start
    issue_op(CMD_FREE, 11'd50, 10'd150);    // ends at the stop, pages free
    issue_op(CMD_FREE, 11'd50, 10'd100);

    // Stop beyond the map: clamped, one page left in the window.
    drain_results();
    set_window(1023, 2047);
    issue_op(CMD_INIT, 11'd0, 10'd0);
    issue_op(CMD_ALLOC, 11'd1, 10'd0);

    // Empty window.
    drain_results();
    set_window(0, 0);
    issue_op(CMD_INIT, 11'd0, 10'd0);
    issue_op(CMD_ALLOC, 11'd1, 10'd0);
    issue_op(CMD_FREE, 11'd1, 10'd0);

    // Random phases, each under its own window; no gaps in the last two.
    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      with_init = 1'b1;
      case (phase)
        0: begin lo = 0;    hi = 1024; end
        1: begin lo = 0;    hi = 2047; end
        2: begin lo = 1023; hi = 2047; end
        3: begin lo = 0;    hi = 0;    end
        4: begin lo = 700;  hi = 300;  end
        default: begin
          with_init = $urandom_range(2) != 0;
          case ($urandom_range(5))
            0: begin lo = 0; hi = 1024; end
            1: begin lo = $urandom_range(255); hi = 1024; end
            2: begin lo = 0; hi = $urandom_range(1024, 64); end
            3: begin lo = $urandom_range(1023); hi = $urandom_range(2047); end
            default: begin
              lo = $urandom_range(511);
              hi = lo + $urandom_range(512, 1);
            end
          endcase
        end
      endcase
      set_window(lo, hi);
      gaps_on = (phase < PHASES - 2) && ($urandom_range(3) != 0);
      if (with_init) issue_op(CMD_INIT, LEN_W'($urandom), PAGE_W'($urandom));
      count = (phase >= 2 && phase <= 4) ? 25 : $urandom_range(85, 65);
      repeat (count) issue_random_op();
    end

    drain_results();
    repeat (SETTLE_CYCLES) next_edge();
    if (faults_seen == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
